// ===== rtl/gmp_pkg.sv =====
`default_nettype none
package gmp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int LOG_STEPS = 30;
    localparam int EXP_STEPS = 30;
    localparam int EXP_K_W   = 34;

    localparam int PIPE_DEPTH = 3 + LOG_STEPS + 3 + EXP_STEPS + 4 + EXP_STEPS + 3;

    localparam logic [30:0] LOG2E_Q30 = 31'h5C551D95;
    localparam logic [60:0] PROD_LIM  = 61'h1 << 60;

    localparam logic signed [63:0] VAL_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_LO = -VAL_HI - 64'sd1;

    typedef enum logic [2:0] {
        REG_AMPLITUDE  = 3'd0,
        REG_WIDTH      = 3'd1,
        REG_OFFSET     = 3'd2,
        REG_RISE_EXP   = 3'd3,
        REG_DECAY_EXP  = 3'd4,
        REG_BACKGROUND = 3'd5
    } t_reg_index;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_WIDTH_ZERO = 2'd1,
        STATUS_EXPONENT   = 2'd2,
        STATUS_SATURATED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SU_START,
        SU_NORM,
        SU_SQUARE,
        SU_DIVIDE,
        SU_MULTIPLY,
        SU_IDLE
    } t_setup_state;

    typedef struct packed {
        logic signed [31:0] amp;
        logic signed [31:0] wid;
        logic signed [31:0] off;
        logic signed [23:0] m;
        logic signed [23:0] n;
        logic signed [31:0] bck;
    } t_cfg;

    typedef struct packed {
        logic               busy;
        logic [34:0]        lw;
        logic signed [63:0] t2;
    } t_setup;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] vv;
        logic [63:0] r;
        logic [63:0] bval;
        int          j;
        vv   = v;
        r    = 64'd0;
        bval = 64'h4000_0000_0000_0000;
        for (j = 0; j < 32; j++) begin
            if (vv >= r + bval) begin
                vv = vv - (r + bval);
                r  = (r >> 1) + bval;
            end else begin
                r = r >> 1;
            end
            bval = bval >> 2;
        end
        return r;
    endfunction

    // Root 2^(2^-i) in Q30, each one the square root of the one before.
    function automatic logic [31:0] f_exp2_root(input int i);
        logic [63:0] root;
        int          j;
        root = 64'd2 << 30;
        for (j = 1; j <= EXP_STEPS; j++) begin
            if (j <= i) begin
                root = f_isqrt(root << 30);
            end
        end
        return root[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gmp_exp2.sv =====
`default_nettype none
module gmp_exp2
    import gmp_pkg::*;
(
    input  logic                       i_clk,
    input  logic [29:0]                i_frac,
    input  logic signed [EXP_K_W-1:0]  i_k,
    output logic [30:0]                o_res,
    output logic signed [EXP_K_W-1:0]  o_k
);

    logic [30:0]               r_res  [EXP_STEPS];
    logic [29:0]               r_frac [EXP_STEPS];
    logic signed [EXP_K_W-1:0] r_k    [EXP_STEPS];

    for (genvar s = 0; s < EXP_STEPS; s++) begin : g_step
        localparam logic [31:0] ROOT = f_exp2_root(s + 1);
        logic [30:0]               w_res;
        logic [29:0]               w_frac;
        logic signed [EXP_K_W-1:0] w_k;
        logic [61:0]               w_prod;

        if (s == 0) begin : g_first
            assign w_res  = 31'h4000_0000;
            assign w_frac = i_frac;
            assign w_k    = i_k;
        end else begin : g_next
            assign w_res  = r_res[s-1];
            assign w_frac = r_frac[s-1];
            assign w_k    = r_k[s-1];
        end

        assign w_prod = 62'(w_res) * 62'(ROOT[30:0]);

        always_ff @(posedge i_clk) begin
            r_res[s]  <= w_frac[EXP_STEPS-1-s] ? w_prod[60:30] : w_res;
            r_frac[s] <= w_frac;
            r_k[s]    <= w_k;
        end
    end

    assign o_res = r_res[EXP_STEPS-1];
    assign o_k   = r_k[EXP_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/gmp_setup.sv =====
`default_nettype none
module gmp_setup
    import gmp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_restart,
    input  t_cfg   i_cfg,
    output t_setup o_setup
);

    t_setup_state r_state;
    t_setup_state n_state;

    logic [63:0]        r_u;
    logic [5:0]         r_p;
    logic [30:0]        r_mm;
    logic [29:0]        r_frac;
    logic [5:0]         r_cnt;
    logic               r_pass;
    logic [34:0]        r_lw;
    logic [23:0]        r_rem;
    logic [53:0]        r_quo;
    logic [36:0]        r_dmag;
    logic               r_dneg;
    logic [89:0]        r_acc;
    logic signed [63:0] r_t2;

    logic [32:0]        w_wabs;
    logic [23:0]        w_am;
    logic [23:0]        w_an;
    logic [53:0]        w_div_n;
    logic [61:0]        w_sq;
    logic [30:0]        n_mm;
    logic [29:0]        n_frac;
    logic [24:0]        w_rem_sh;
    logic               w_div_ge;
    logic [23:0]        n_rem;
    logic [53:0]        n_quo;
    logic signed [37:0] w_d;
    logic [89:0]        n_acc;
    logic [59:0]        w_t2_mag;

    always_comb begin
        w_wabs  = i_cfg.wid[31] ? 33'(-{i_cfg.wid[31], i_cfg.wid}) : {1'b0, i_cfg.wid};
        if (w_wabs == 33'd0) begin
            w_wabs = 33'd1;
        end
        w_am    = i_cfg.m[23] ? 24'(-i_cfg.m) : 24'(i_cfg.m);
        w_an    = i_cfg.n[23] ? 24'(-i_cfg.n) : 24'(i_cfg.n);
        if (w_an == 24'd0) begin
            w_an = 24'd1;
        end
        w_div_n = {w_am, 30'd0};

        w_sq   = 62'(r_mm) * 62'(r_mm);
        n_frac = r_frac;
        if (w_sq[61]) begin
            n_mm = w_sq[61:31];
            n_frac[r_cnt[4:0]] = 1'b1;
        end else begin
            n_mm = w_sq[60:30];
        end

        w_rem_sh = {r_rem, w_div_n[r_cnt]};
        w_div_ge = w_rem_sh >= {1'b0, w_an};
        n_rem    = w_div_ge ? 24'(w_rem_sh - {1'b0, w_an}) : w_rem_sh[23:0];
        n_quo    = {r_quo[52:0], w_div_ge};

        w_d = $signed(38'(LOG2E_Q30)) + $signed(38'(29) << 30)
            - $signed({2'b00, r_p, n_frac});

        n_acc    = {r_acc[88:0], 1'b0} + (r_quo[r_cnt] ? 90'(r_dmag) : 90'd0);
        w_t2_mag = n_acc[89:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_START;
        end else if (i_restart) begin
            r_state <= SU_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SU_START: begin
                n_state = SU_NORM;
            end
            SU_NORM: begin
                if (r_u[63]) begin
                    n_state = SU_SQUARE;
                end
            end
            SU_SQUARE: begin
                if (r_cnt == 6'd0) begin
                    n_state = r_pass ? SU_MULTIPLY : SU_DIVIDE;
                end
            end
            SU_DIVIDE: begin
                if (r_cnt == 6'd0) begin
                    n_state = SU_NORM;
                end
            end
            SU_MULTIPLY: begin
                if (r_cnt == 6'd0) begin
                    n_state = SU_IDLE;
                end
            end
            SU_IDLE: begin
                n_state = SU_IDLE;
            end
            default: begin
                n_state = SU_START;
            end
        endcase
    end

    always_comb begin
        o_setup.busy = (r_state != SU_IDLE);
        o_setup.lw   = r_lw;
        o_setup.t2   = r_t2;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SU_START: begin
                r_u    <= {31'd0, w_wabs};
                r_p    <= 6'd63;
                r_pass <= 1'b0;
            end
            SU_NORM: begin
                if (!r_u[63]) begin
                    r_u <= {r_u[62:0], 1'b0};
                    r_p <= r_p - 6'd1;
                end else begin
                    r_mm   <= r_u[63:33];
                    r_frac <= 30'd0;
                    r_cnt  <= 6'(LOG_STEPS - 1);
                end
            end
            SU_SQUARE: begin
                r_mm   <= n_mm;
                r_frac <= n_frac;
                if (r_cnt == 6'd0) begin
                    if (!r_pass) begin
                        r_lw  <= {r_p[4:0], n_frac};
                        r_rem <= 24'd0;
                        r_quo <= 54'd0;
                    end else begin
                        r_dneg <= w_d[37];
                        r_dmag <= w_d[37] ? 37'(-w_d) : w_d[36:0];
                        r_acc  <= 90'd0;
                    end
                    r_cnt <= 6'd53;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            SU_DIVIDE: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_u    <= (n_quo == 54'd0) ? 64'd1 : {10'd0, n_quo};
                    r_p    <= 6'd63;
                    r_pass <= 1'b1;
                end
            end
            SU_MULTIPLY: begin
                r_acc <= n_acc;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_t2 <= r_dneg ? -$signed({4'd0, w_t2_mag}) : $signed({4'd0, w_t2_mag});
                end
            end
            SU_IDLE: begin
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/generalized_maxwell_peak_eval.sv =====
`default_nettype none
// Channel         Direction  Signals
// command         in/out     start, busy, i_sample_position
// configuration   in/out     i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// result          out        o_result_strobe, o_peak_value, o_status
//
// One sample is taken in every cycle in which start is high and busy is low; its result
// passes through the 30-step log2 squaring chain and the two 30-step exp2 root chains.
// After reset and after every configuration write, a setup sequencer with one shared
// multiplier, divider and accumulator runs with busy high.
// Reset is synchronous and clears the valid line and the sequencer; results cannot be
// held off, so the pipeline never stalls.
module generalized_maxwell_peak_eval
    import gmp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_sample_position,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_result_strobe,
    output logic signed [31:0] o_peak_value,
    output logic [1:0]         o_status
);

    t_cfg   r_cfg;
    t_setup w_setup;
    logic   w_cfg_we;
    logic   w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;
    assign busy        = w_setup.busy;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp <= 32'sd65536;
            r_cfg.wid <= 32'sd65536;
            r_cfg.off <= 32'sd0;
            r_cfg.m   <= 24'sd65536;
            r_cfg.n   <= 24'sd131072;
            r_cfg.bck <= 32'sd0;
        end else if (w_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_AMPLITUDE:  r_cfg.amp <= i_cfg_data;
                REG_WIDTH:      r_cfg.wid <= i_cfg_data;
                REG_OFFSET:     r_cfg.off <= i_cfg_data;
                REG_RISE_EXP:   r_cfg.m   <= i_cfg_data[23:0];
                REG_DECAY_EXP:  r_cfg.n   <= i_cfg_data[23:0];
                REG_BACKGROUND: r_cfg.bck <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gmp_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_we),
        .i_cfg     (r_cfg),
        .o_setup   (w_setup)
    );

    logic r_vld [PIPE_DEPTH];
    logic r_le  [PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_DEPTH; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= w_accept;
            for (int j = 1; j < PIPE_DEPTH; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    logic signed [32:0] w_diff;
    logic               w_le;
    logic [31:0]        r_a_t;
    logic [31:0]        r_b_t;
    logic [4:0]         r_b_p;
    logic [4:0]         w_msb;
    logic [31:0]        w_norm;
    logic [30:0]        r_c_mm;
    logic [4:0]         r_c_p;

    assign w_diff = 33'(i_sample_position) - 33'(r_cfg.off);
    assign w_le   = (w_diff <= 33'sd0);

    always_ff @(posedge i_clk) begin
        r_le[0] <= w_le;
        for (int j = 1; j < PIPE_DEPTH - 1; j++) begin
            r_le[j] <= r_le[j-1];
        end
    end

    always_comb begin
        w_msb = 5'd0;
        for (int j = 0; j < 32; j++) begin
            if (r_a_t[j]) begin
                w_msb = 5'(j);
            end
        end
        w_norm = r_b_t << (5'd31 - r_b_p);
    end

    always_ff @(posedge i_clk) begin
        r_a_t  <= w_le ? 32'd1 : w_diff[31:0];
        r_b_t  <= r_a_t;
        r_b_p  <= w_msb;
        r_c_mm <= w_norm[31:1];
        r_c_p  <= r_b_p;
    end

    logic [30:0] r_sq_mm   [LOG_STEPS];
    logic [29:0] r_sq_frac [LOG_STEPS];
    logic [4:0]  r_sq_p    [LOG_STEPS];

    for (genvar s = 0; s < LOG_STEPS; s++) begin : g_log
        logic [30:0] w_mm;
        logic [29:0] w_frac;
        logic [4:0]  w_p;
        logic [61:0] w_sq;

        if (s == 0) begin : g_first
            assign w_mm   = r_c_mm;
            assign w_frac = 30'd0;
            assign w_p    = r_c_p;
        end else begin : g_next
            assign w_mm   = r_sq_mm[s-1];
            assign w_frac = r_sq_frac[s-1];
            assign w_p    = r_sq_p[s-1];
        end

        assign w_sq = 62'(w_mm) * 62'(w_mm);

        always_ff @(posedge i_clk) begin
            r_sq_mm[s]   <= w_sq[61] ? w_sq[61:31] : w_sq[60:30];
            r_sq_frac[s] <= w_frac | (30'(w_sq[61]) << (LOG_STEPS - 1 - s));
            r_sq_p[s]    <= w_p;
        end
    end

    logic signed [35:0] w_l;
    logic               r_l_neg;
    logic [34:0]        r_l_mag;
    logic [23:0]        w_am;
    logic [23:0]        w_an;
    logic [58:0]        r_m_pe;
    logic [58:0]        r_m_pt;
    logic               r_m_neg_e;
    logic               r_m_neg_t;
    logic [58:0]        w_qe;
    logic [58:0]        w_qt;
    logic signed [63:0] w_e1;
    logic signed [63:0] r_n_e1;
    logic signed [63:0] r_n_t1;
    logic               r_n_van;

    assign w_l  = $signed({1'b0, r_sq_p[LOG_STEPS-1], r_sq_frac[LOG_STEPS-1]})
                - $signed({1'b0, w_setup.lw});
    assign w_am = r_cfg.m[23] ? 24'(-r_cfg.m) : 24'(r_cfg.m);
    assign w_an = r_cfg.n[23] ? 24'(-r_cfg.n) : 24'(r_cfg.n);
    assign w_qe = r_m_pe >> FRAC_BITS;
    assign w_qt = r_m_pt >> FRAC_BITS;
    assign w_e1 = r_m_neg_e ? -$signed({5'd0, w_qe}) : $signed({5'd0, w_qe});

    always_ff @(posedge i_clk) begin
        r_l_neg   <= w_l[35];
        r_l_mag   <= w_l[35] ? 35'(-w_l) : w_l[34:0];
        r_m_pe    <= 59'(w_an) * 59'(r_l_mag);
        r_m_pt    <= 59'(w_am) * 59'(r_l_mag);
        r_m_neg_e <= r_cfg.n[23] ^ r_l_neg;
        r_m_neg_t <= r_cfg.m[23] ^ r_l_neg;
        r_n_e1    <= w_e1;
        r_n_t1    <= r_m_neg_t ? -$signed({5'd0, w_qt}) : $signed({5'd0, w_qt});
        r_n_van   <= (w_e1 >= (64'sd32 <<< 30));
    end

    logic [30:0]               w_u1_res;
    logic signed [EXP_K_W-1:0] w_u1_k;

    gmp_exp2 u_exp_decay (
        .i_clk  (i_clk),
        .i_frac (r_n_e1[29:0]),
        .i_k    (r_n_e1[63:30]),
        .o_res  (w_u1_res),
        .o_k    (w_u1_k)
    );

    logic signed [63:0] r_t1_d  [EXP_STEPS+3];
    logic               r_van_d [EXP_STEPS+3];

    always_ff @(posedge i_clk) begin
        r_t1_d[0]  <= r_n_t1;
        r_van_d[0] <= r_n_van;
        for (int j = 1; j < EXP_STEPS + 3; j++) begin
            r_t1_d[j]  <= r_t1_d[j-1];
            r_van_d[j] <= r_van_d[j-1];
        end
    end

    logic [30:0]        r_es_small;
    logic               r_es_kpos;
    logic [4:0]         r_es_ks;
    logic [EXP_K_W-1:0] w_u1_kneg;
    logic [61:0]        r_pp_prod;
    logic               r_pp_kpos;
    logic [4:0]         r_pp_ks;
    logic [93:0]        w_q_sh;
    logic [62:0]        w_q;
    logic [60:0]        r_q_t3;
    logic signed [63:0] w_g;
    logic signed [63:0] r_g;

    assign w_u1_kneg = EXP_K_W'(-w_u1_k);

    always_comb begin
        w_q_sh = {32'd0, r_pp_prod} << r_pp_ks;
        w_q    = r_pp_kpos ? w_q_sh[93:31] : 63'(r_pp_prod >> 31);
        w_g    = r_t1_d[EXP_STEPS+2] + w_setup.t2 - $signed({3'd0, r_q_t3});
        if (r_van_d[EXP_STEPS+2]) begin
            w_g = {1'b1, 63'd0};
        end else if (w_g > 64'sd0) begin
            w_g = 64'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_es_kpos <= !w_u1_k[EXP_K_W-1];
        r_es_ks   <= w_u1_k[4:0];
        if (!w_u1_k[EXP_K_W-1]) begin
            r_es_small <= w_u1_res;
        end else if (w_u1_k <= -EXP_K_W'(31)) begin
            r_es_small <= 31'd0;
        end else begin
            r_es_small <= w_u1_res >> w_u1_kneg[4:0];
        end
        r_pp_prod <= 62'(LOG2E_Q30) * 62'(r_es_small);
        r_pp_kpos <= r_es_kpos;
        r_pp_ks   <= r_es_ks;
        r_q_t3    <= (w_q > 63'(PROD_LIM)) ? PROD_LIM : w_q[60:0];
        r_g       <= w_g;
    end

    logic [30:0]               w_u2_res;
    logic signed [EXP_K_W-1:0] w_u2_k;
    logic [EXP_K_W-1:0]        w_u2_kneg;

    gmp_exp2 u_exp_shape (
        .i_clk  (i_clk),
        .i_frac (r_g[29:0]),
        .i_k    (r_g[63:30]),
        .o_res  (w_u2_res),
        .o_k    (w_u2_k)
    );

    assign w_u2_kneg = EXP_K_W'(-w_u2_k);

    logic [30:0]        r_sh;
    logic signed [63:0] r_pr;
    logic signed [63:0] w_val;
    logic signed [63:0] w_clamped;
    logic               w_sat;
    logic signed [63:0] w_bck;
    logic signed [31:0] r_peak_value;
    t_status            r_status;
    t_status            n_status;
    logic signed [31:0] n_peak_value;

    always_ff @(posedge i_clk) begin
        r_sh <= (w_u2_k <= -EXP_K_W'(31)) ? 31'd0 : (w_u2_res >> w_u2_kneg[4:0]);
        r_pr <= 64'(r_cfg.amp) * $signed({33'd0, r_sh});
    end

    always_comb begin
        w_bck = 64'(r_cfg.bck);
        w_val = r_le[PIPE_DEPTH-2] ? w_bck : (w_bck + (r_pr >>> 30));
        w_sat = 1'b0;
        if (w_val > VAL_HI) begin
            w_clamped = VAL_HI;
            w_sat     = 1'b1;
        end else if (w_val < VAL_LO) begin
            w_clamped = VAL_LO;
            w_sat     = 1'b1;
        end else begin
            w_clamped = w_val;
        end

        priority if (r_cfg.wid == 32'sd0) begin
            n_status     = STATUS_WIDTH_ZERO;
            n_peak_value = 32'sd0;
        end else if ((r_cfg.m == 24'sd0) || (r_cfg.n == 24'sd0)
                     || (r_cfg.m[23] != r_cfg.n[23])) begin
            n_status     = STATUS_EXPONENT;
            n_peak_value = 32'sd0;
        end else begin
            n_status     = w_sat ? STATUS_SATURATED : STATUS_OK;
            n_peak_value = w_clamped[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak_value <= n_peak_value;
        r_status     <= n_status;
    end

    assign o_result_strobe = r_vld[PIPE_DEPTH-1];
    assign o_peak_value    = r_peak_value;
    assign o_status        = r_status;

endmodule
`default_nettype wire
